FILE: hw/rtl/uasd_pkg.sv
package uasd_pkg;

   // request action codes
   localparam logic [1:0] ACT_FIRST   = 2'd0;
   localparam logic [1:0] ACT_SECOND  = 2'd1;
   localparam logic [1:0] ACT_COMPARE = 2'd2;

   // chunk kinds
   localparam logic [1:0] KIND_FIRST  = 2'd0;
   localparam logic [1:0] KIND_SECOND = 2'd1;
   localparam logic [1:0] KIND_COMMON = 2'd2;

   // occurrence state in a position map entry
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONCE = 2'd1;
   localparam logic [1:0] SEEN_MORE = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] action;
      logic [8:0] symbol;
   } append_type;

   typedef enum logic [28:0] {
      S_IDLE       = 29'd1 << 0,
      S_CLEAR      = 29'd1 << 1,
      S_NOTE_RD    = 29'd1 << 2,
      S_NOTE_MAP   = 29'd1 << 3,
      S_NOTE_WR    = 29'd1 << 4,
      S_SCAN_TOP   = 29'd1 << 5,
      S_SCAN_RD    = 29'd1 << 6,
      S_SCAN_SYM   = 29'd1 << 7,
      S_SCAN_CHK   = 29'd1 << 8,
      S_BACK_RD    = 29'd1 << 9,
      S_BACK_CHK   = 29'd1 << 10,
      S_FWD_RD     = 29'd1 << 11,
      S_FWD_CHK    = 29'd1 << 12,
      S_PUT_FIRST  = 29'd1 << 13,
      S_PUT_COMMON = 29'd1 << 14,
      S_ADD        = 29'd1 << 15,
      S_GAP_TOP    = 29'd1 << 16,
      S_GAP_RD     = 29'd1 << 17,
      S_GAP_CHK    = 29'd1 << 18,
      S_ORD_RD     = 29'd1 << 19,
      S_ORD_CHK    = 29'd1 << 20,
      S_ORD_BRD    = 29'd1 << 21,
      S_ORD_BCHK   = 29'd1 << 22,
      S_ORD_SHIFT  = 29'd1 << 23,
      S_ORD_MOVE   = 29'd1 << 24,
      S_EMIT_RD    = 29'd1 << 25,
      S_EMIT_OUT   = 29'd1 << 26,
      S_OVF        = 29'd1 << 27,
      S_DONE       = 29'd1 << 28
   } state_type;

endpackage

FILE: hw/rtl/uasd_seq_store.sv
module uasd_seq_store #(
   parameter int MAX_LENGTH = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  uasd_pkg::append_type              append,
   input  logic                              clear,
   input  logic [$clog2(MAX_LENGTH)-1:0]     rd1_addr,
   input  logic [$clog2(MAX_LENGTH)-1:0]     rd2_addr,
   output logic [8:0]                        rd1_data,
   output logic [8:0]                        rd2_data,
   output logic [$clog2(MAX_LENGTH+1)-1:0]   count1,
   output logic [$clog2(MAX_LENGTH+1)-1:0]   count2,
   output logic                              dropped
);
   import uasd_pkg::*;

   localparam int LW = $clog2(MAX_LENGTH);
   localparam int CW = $clog2(MAX_LENGTH + 1);

   logic [8:0]    first_mem  [MAX_LENGTH];
   logic [8:0]    second_mem [MAX_LENGTH];
   logic [CW-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic          drop_ff, drop_in;
   logic          wr1, wr2;
   logic [8:0]    rd1_ff, rd2_ff;

   always_comb begin
      cnt1_in = cnt1_ff;
      cnt2_in = cnt2_ff;
      drop_in = drop_ff;
      wr1     = 1'b0;
      wr2     = 1'b0;
      if (clear) begin
         cnt1_in = '0;
         cnt2_in = '0;
         drop_in = 1'b0;
      end else if (append.valid) begin
         case (append.action)
            ACT_FIRST: begin
               if (cnt1_ff < MAX_LENGTH) begin
                  wr1     = 1'b1;
                  cnt1_in = cnt1_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
            ACT_SECOND: begin
               if (cnt2_ff < MAX_LENGTH) begin
                  wr2     = 1'b1;
                  cnt2_in = cnt2_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff <= '0;
         cnt2_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         cnt1_ff <= cnt1_in;
         cnt2_ff <= cnt2_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr1) begin
         first_mem[cnt1_ff[LW-1:0]] <= append.symbol;
      end
      if (wr2) begin
         second_mem[cnt2_ff[LW-1:0]] <= append.symbol;
      end
      rd1_ff <= first_mem[rd1_addr];
      rd2_ff <= second_mem[rd2_addr];
   end

   assign rd1_data = rd1_ff;
   assign rd2_data = rd2_ff;
   assign count1   = cnt1_ff;
   assign count2   = cnt2_ff;
   assign dropped  = drop_ff;

endmodule

FILE: hw/rtl/uasd_pos_map.sv
module uasd_pos_map #(
   parameter int MAX_LENGTH   = 512,
   parameter int SYMBOL_COUNT = 512
) (
   input  logic                              clock,
   input  logic                              wr1_en,
   input  logic                              wr2_en,
   input  logic [$clog2(SYMBOL_COUNT)-1:0]   wr_addr,
   input  logic [$clog2(MAX_LENGTH)+1:0]     wr_data,
   input  logic [$clog2(SYMBOL_COUNT)-1:0]   rd_addr,
   output logic [$clog2(MAX_LENGTH)+1:0]     rd1_data,
   output logic [$clog2(MAX_LENGTH)+1:0]     rd2_data
);
   localparam int EW = $clog2(MAX_LENGTH) + 2;

   logic [EW-1:0] first_map  [SYMBOL_COUNT];
   logic [EW-1:0] second_map [SYMBOL_COUNT];
   logic [EW-1:0] rd1_ff, rd2_ff;

   always_ff @(posedge clock) begin
      if (wr1_en) begin
         first_map[wr_addr] <= wr_data;
      end
      if (wr2_en) begin
         second_map[wr_addr] <= wr_data;
      end
      rd1_ff <= first_map[rd_addr];
      rd2_ff <= second_map[rd_addr];
   end

   assign rd1_data = rd1_ff;
   assign rd2_data = rd2_ff;

endmodule

FILE: hw/rtl/uasd_chunk_store.sv
module uasd_chunk_store #(
   parameter int MAX_CHUNKS = 20,
   parameter int REC_WIDTH  = 30
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_CHUNKS)-1:0]   wr_addr,
   input  logic [REC_WIDTH-1:0]            wr_data,
   input  logic [$clog2(MAX_CHUNKS)-1:0]   rd_addr,
   output logic [REC_WIDTH-1:0]            rd_data
);
   logic [REC_WIDTH-1:0] chunk_mem [MAX_CHUNKS];
   logic [REC_WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chunk_mem[wr_addr] <= wr_data;
      end
      rd_ff <= chunk_mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

FILE: hw/rtl/unique_anchor_sequence_diff.sv
// Unique-anchor sequence diff.
// Request channel (req_valid / req_stall, req_action, req_symbol): action
// append-first or append-second stores one symbol per cycle while req_stall is low; a compare
// request runs the diff and then clears both sequences. Appends past
// MAX_LENGTH are dropped and reported as truncated on the next compare.
// Response channel (rsp_valid / rsp_stall): one response per chunk, in the
// reordered chunk order, rsp_last_chunk on the final one. More than
// MAX_CHUNKS chunks give a single response with rsp_overflow set.
// A compare holds req_stall while it clears the position maps (one entry
// a cycle), runs the note pass over each stored symbol (sequence read, map
// read, map write), scans for unique anchors and grows them, makes the chunk
// passes over the chunk store (one read and one write port) and emits the
// responses. Memory reads are registered.
// A stalled response holds in the output register; the compare waits.
// Reset (synchronous, active high) empties both sequences and clears the
// truncated flag; the position maps need no reset since each compare
// clears them first.
module unique_anchor_sequence_diff #(
   parameter int MAX_LENGTH   = 512,
   parameter int SYMBOL_COUNT = 512,
   parameter int MAX_CHUNKS   = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [8:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_chunk_kind,
   output logic [8:0] rsp_start_first,
   output logic [8:0] rsp_start_second,
   output logic [9:0] rsp_chunk_length,
   output logic       rsp_last_chunk,
   output logic       rsp_overflow,
   output logic       rsp_truncated
);
   import uasd_pkg::*;

   localparam int LW  = $clog2(MAX_LENGTH);
   localparam int CW  = $clog2(MAX_LENGTH + 1);
   localparam int SW  = $clog2(SYMBOL_COUNT);
   localparam int EW  = LW + 2;
   localparam int KW  = $clog2(MAX_CHUNKS);
   localparam int KCW = $clog2(MAX_CHUNKS + 1);
   // chunk record: kind, offset first, offset second, length
   localparam int RW  = 2 + LW + LW + CW;

   state_type state_ff, state_in, next_ff, next_in;

   logic [SW-1:0]  clr_ff, clr_in;
   logic           pass_ff, pass_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [8:0]     sym_ff, sym_in;
   logic [CW-1:0]  i_ff, i_in, ii_ff, ii_in, i0_ff, i0_in;
   logic [CW-1:0]  j0_ff, j0_in, jj_ff, jj_in, j_ff, j_in;
   logic [KCW-1:0] total_ff, total_in, h_ff, h_in;
   logic [KCW-1:0] oj_ff, oj_in, oi_ff, oi_in, oh_ff, oh_in, k_ff, k_in;
   logic [RW-1:0]  tmp_ff, tmp_in, rec_ff, rec_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [8:0] sf_ff, sf_in, ss_ff, ss_in;
   logic [9:0] len_ff, len_in;
   logic       last_ff, last_in, ovf_ff, ovf_in, trunc_ff, trunc_in;

   append_type     append;
   logic           seq_clear;
   logic [LW-1:0]  sq_rd1_addr, sq_rd2_addr;
   logic [8:0]     sq_rd1, sq_rd2;
   logic [CW-1:0]  len1, len2;
   logic           dropped;

   logic           mp_wr1, mp_wr2;
   logic [SW-1:0]  mp_wr_addr, mp_rd_addr;
   logic [EW-1:0]  mp_wr_data, mp_rd1, mp_rd2, mp_cur;

   logic           ck_wr;
   logic [KW-1:0]  ck_wr_addr, ck_rd_addr;
   logic [RW-1:0]  ck_wr_data, ck_rd;

   logic           accept, out_free;
   logic [8:0]     seq_sym;
   logic [1:0]     c_kind;
   logic [LW-1:0]  c_off1, c_off2, t_off2;
   logic [CW-1:0]  c_len, c_off2_w;
   logic [CW:0]    c_end;
   logic [CW-1:0]  i0_m1, j0_m1, ii_p1, jj_p1;
   logic [KCW-1:0] oi_m1, oh_m1, total_m1;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign c_kind   = ck_rd[RW-1 -: 2];
   assign c_off1   = ck_rd[RW-3 -: LW];
   assign c_off2   = ck_rd[CW+LW-1 -: LW];
   assign c_len    = ck_rd[CW-1:0];
   assign c_off2_w = CW'(c_off2);
   assign c_end    = {1'b0, c_off2_w} + {1'b0, c_len};
   assign t_off2   = tmp_ff[CW+LW-1 -: LW];

   assign i0_m1    = i0_ff - 1'b1;
   assign j0_m1    = j0_ff - 1'b1;
   assign ii_p1    = ii_ff + 1'b1;
   assign jj_p1    = jj_ff + 1'b1;
   assign oi_m1    = oi_ff - 1'b1;
   assign oh_m1    = oh_ff - 1'b1;
   assign total_m1 = total_ff - 1'b1;

   assign seq_sym  = pass_ff ? sq_rd2 : sq_rd1;
   assign mp_cur   = pass_ff ? mp_rd2 : mp_rd1;

   always_comb begin
      append.valid  = accept && (req_action == ACT_FIRST || req_action == ACT_SECOND);
      append.action = req_action;
      append.symbol = req_symbol;
   end

   always_comb begin
      state_in = state_ff;
      next_in  = next_ff;
      clr_in   = clr_ff;
      pass_in  = pass_ff;
      n_in     = n_ff;
      sym_in   = sym_ff;
      i_in     = i_ff;
      ii_in    = ii_ff;
      i0_in    = i0_ff;
      j0_in    = j0_ff;
      jj_in    = jj_ff;
      j_in     = j_ff;
      total_in = total_ff;
      h_in     = h_ff;
      oj_in    = oj_ff;
      oi_in    = oi_ff;
      oh_in    = oh_ff;
      k_in     = k_ff;
      tmp_in   = tmp_ff;
      rec_in   = rec_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in  = kind_ff;
      sf_in    = sf_ff;
      ss_in    = ss_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      ovf_in   = ovf_ff;
      trunc_in = trunc_ff;

      seq_clear   = 1'b0;
      sq_rd1_addr = ii_ff[LW-1:0];
      sq_rd2_addr = jj_ff[LW-1:0];
      mp_wr1      = 1'b0;
      mp_wr2      = 1'b0;
      mp_wr_addr  = clr_ff;
      mp_wr_data  = '0;
      mp_rd_addr  = SW'(seq_sym);
      ck_wr       = 1'b0;
      ck_wr_addr  = total_ff[KW-1:0];
      ck_wr_data  = rec_ff;
      ck_rd_addr  = k_ff[KW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_action == ACT_COMPARE) begin
               clr_in   = '0;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            // wipe both position maps, one symbol a cycle
            mp_wr1     = 1'b1;
            mp_wr2     = 1'b1;
            mp_wr_addr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == SW'(SYMBOL_COUNT - 1)) begin
               pass_in  = 1'b0;
               n_in     = '0;
               state_in = S_NOTE_RD;
            end
         end
         S_NOTE_RD: begin
            sq_rd1_addr = n_ff[LW-1:0];
            sq_rd2_addr = n_ff[LW-1:0];
            if (n_ff == (pass_ff ? len2 : len1)) begin
               n_in = '0;
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else begin
                  i_in     = '0;
                  total_in = '0;
                  state_in = S_SCAN_TOP;
               end
            end else begin
               state_in = S_NOTE_MAP;
            end
         end
         S_NOTE_MAP: begin
            sym_in     = seq_sym;
            mp_rd_addr = SW'(seq_sym);
            if (seq_sym < SYMBOL_COUNT) begin
               state_in = S_NOTE_WR;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_NOTE_RD;
            end
         end
         S_NOTE_WR: begin
            // update the first-occurrence record of this symbol
            mp_wr1     = !pass_ff;
            mp_wr2     = pass_ff;
            mp_wr_addr = SW'(sym_ff);
            if (mp_cur[EW-1 -: 2] == SEEN_NONE) begin
               mp_wr_data = {SEEN_ONCE, n_ff[LW-1:0]};
            end else begin
               mp_wr_data = {SEEN_MORE, mp_cur[LW-1:0]};
            end
            n_in     = n_ff + 1'b1;
            state_in = S_NOTE_RD;
         end
         S_SCAN_TOP: begin
            if (i_ff == len1) begin
               j_in     = '0;
               state_in = S_GAP_TOP;
            end else begin
               ii_in    = i_ff;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            sq_rd1_addr = ii_ff[LW-1:0];
            if (ii_ff == len1) begin
               rec_in   = {KIND_FIRST, i_ff[LW-1:0], {LW{1'b0}}, CW'(len1 - i_ff)};
               j_in     = '0;
               next_in  = S_GAP_TOP;
               state_in = S_ADD;
            end else begin
               state_in = S_SCAN_SYM;
            end
         end
         S_SCAN_SYM: begin
            sym_in     = sq_rd1;
            mp_rd_addr = SW'(sq_rd1);
            if (sq_rd1 < SYMBOL_COUNT) begin
               state_in = S_SCAN_CHK;
            end else begin
               ii_in    = ii_p1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_CHK: begin
            if (mp_rd1[EW-1 -: 2] == SEEN_ONCE && mp_rd2[EW-1 -: 2] == SEEN_ONCE) begin
               jj_in    = CW'(mp_rd2[LW-1:0]);
               j0_in    = CW'(mp_rd2[LW-1:0]);
               i0_in    = ii_ff;
               state_in = S_BACK_RD;
            end else begin
               ii_in    = ii_p1;
               state_in = S_SCAN_RD;
            end
         end
         S_BACK_RD: begin
            sq_rd1_addr = i0_m1[LW-1:0];
            sq_rd2_addr = j0_m1[LW-1:0];
            if (i0_ff > i_ff && j0_ff != '0) begin
               state_in = S_BACK_CHK;
            end else begin
               state_in = S_FWD_RD;
            end
         end
         S_BACK_CHK: begin
            if (sq_rd1 == sq_rd2) begin
               i0_in    = i0_m1;
               j0_in    = j0_m1;
               state_in = S_BACK_RD;
            end else begin
               state_in = S_FWD_RD;
            end
         end
         S_FWD_RD: begin
            sq_rd1_addr = ii_p1[LW-1:0];
            sq_rd2_addr = jj_p1[LW-1:0];
            if (ii_p1 < len1 && jj_p1 < len2) begin
               state_in = S_FWD_CHK;
            end else begin
               state_in = S_PUT_FIRST;
            end
         end
         S_FWD_CHK: begin
            if (sq_rd1 == sq_rd2) begin
               ii_in    = ii_p1;
               jj_in    = jj_p1;
               state_in = S_FWD_RD;
            end else begin
               state_in = S_PUT_FIRST;
            end
         end
         S_PUT_FIRST: begin
            if (i_ff < i0_ff) begin
               rec_in   = {KIND_FIRST, i_ff[LW-1:0], {LW{1'b0}}, CW'(i0_ff - i_ff)};
               next_in  = S_PUT_COMMON;
               state_in = S_ADD;
            end else begin
               state_in = S_PUT_COMMON;
            end
         end
         S_PUT_COMMON: begin
            rec_in   = {KIND_COMMON, i0_ff[LW-1:0], j0_ff[LW-1:0],
                        CW'(ii_ff - i0_ff + 1'b1)};
            i_in     = ii_p1;
            next_in  = S_SCAN_TOP;
            state_in = S_ADD;
         end
         S_ADD: begin
            // append one chunk record, or give up on overflow
            if (total_ff >= MAX_CHUNKS) begin
               state_in = S_OVF;
            end else begin
               ck_wr      = 1'b1;
               ck_wr_addr = total_ff[KW-1:0];
               ck_wr_data = rec_ff;
               total_in   = total_ff + 1'b1;
               state_in   = next_ff;
            end
         end
         S_GAP_TOP: begin
            if (j_ff >= len2) begin
               oj_in    = '0;
               state_in = S_ORD_RD;
            end else begin
               jj_in    = len2;
               h_in     = '0;
               state_in = S_GAP_RD;
            end
         end
         S_GAP_RD: begin
            ck_rd_addr = h_ff[KW-1:0];
            if (h_ff == total_ff) begin
               rec_in   = {KIND_SECOND, {LW{1'b0}}, j_ff[LW-1:0], CW'(jj_ff - j_ff)};
               j_in     = jj_ff;
               next_in  = S_GAP_TOP;
               state_in = S_ADD;
            end else begin
               state_in = S_GAP_CHK;
            end
         end
         S_GAP_CHK: begin
            h_in     = h_ff + 1'b1;
            state_in = S_GAP_RD;
            if (c_kind == KIND_COMMON) begin
               if (c_off2_w <= j_ff && c_end > {1'b0, j_ff}) begin
                  j_in     = c_end[CW-1:0];
                  state_in = S_GAP_TOP;
               end else if (c_off2_w > j_ff && c_off2_w < jj_ff) begin
                  jj_in = c_off2_w;
               end
            end
         end
         S_ORD_RD: begin
            ck_rd_addr = oj_ff[KW-1:0];
            if (oj_ff == total_ff) begin
               k_in     = '0;
               state_in = (total_ff == '0) ? S_DONE : S_EMIT_RD;
            end else begin
               state_in = S_ORD_CHK;
            end
         end
         S_ORD_CHK: begin
            tmp_in = ck_rd;
            oi_in  = oj_ff;
            oh_in  = oj_ff;
            if (c_kind == KIND_SECOND) begin
               state_in = S_ORD_BRD;
            end else begin
               oj_in    = oj_ff + 1'b1;
               state_in = S_ORD_RD;
            end
         end
         S_ORD_BRD: begin
            ck_rd_addr = oi_m1[KW-1:0];
            state_in   = (oi_ff != '0) ? S_ORD_BCHK : S_ORD_SHIFT;
         end
         S_ORD_BCHK: begin
            // move the second-only chunk up past first-only chunks and
            // common chunks that sit later in the second sequence
            if (c_kind == KIND_FIRST || (c_kind == KIND_COMMON && c_off2 > t_off2)) begin
               oi_in    = oi_m1;
               state_in = S_ORD_BRD;
            end else begin
               state_in = S_ORD_SHIFT;
            end
         end
         S_ORD_SHIFT: begin
            ck_rd_addr = oh_m1[KW-1:0];
            if (oh_ff > oi_ff) begin
               state_in = S_ORD_MOVE;
            end else begin
               ck_wr      = (oi_ff != oj_ff);
               ck_wr_addr = oi_ff[KW-1:0];
               ck_wr_data = tmp_ff;
               oj_in      = oj_ff + 1'b1;
               state_in   = S_ORD_RD;
            end
         end
         S_ORD_MOVE: begin
            ck_wr      = 1'b1;
            ck_wr_addr = oh_ff[KW-1:0];
            ck_wr_data = ck_rd;
            oh_in      = oh_m1;
            state_in   = S_ORD_SHIFT;
         end
         S_EMIT_RD: begin
            ck_rd_addr = k_ff[KW-1:0];
            state_in   = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            ck_rd_addr = k_ff[KW-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in  = c_kind;
               sf_in    = 9'(c_off1);
               ss_in    = 9'(c_off2);
               len_in   = 10'(c_len);
               last_in  = (k_ff == total_m1);
               ovf_in   = 1'b0;
               trunc_in = dropped;
               k_in     = k_ff + 1'b1;
               state_in = (k_ff == total_m1) ? S_DONE : S_EMIT_RD;
            end
         end
         S_OVF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in  = KIND_FIRST;
               sf_in    = '0;
               ss_in    = '0;
               len_in   = '0;
               last_in  = 1'b1;
               ovf_in   = 1'b1;
               trunc_in = dropped;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // empty both sequences and drop the truncated flag
            seq_clear = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff  <= next_in;
      clr_ff   <= clr_in;
      pass_ff  <= pass_in;
      n_ff     <= n_in;
      sym_ff   <= sym_in;
      i_ff     <= i_in;
      ii_ff    <= ii_in;
      i0_ff    <= i0_in;
      j0_ff    <= j0_in;
      jj_ff    <= jj_in;
      j_ff     <= j_in;
      total_ff <= total_in;
      h_ff     <= h_in;
      oj_ff    <= oj_in;
      oi_ff    <= oi_in;
      oh_ff    <= oh_in;
      k_ff     <= k_in;
      tmp_ff   <= tmp_in;
      rec_ff   <= rec_in;
      kind_ff  <= kind_in;
      sf_ff    <= sf_in;
      ss_ff    <= ss_in;
      len_ff   <= len_in;
      last_ff  <= last_in;
      ovf_ff   <= ovf_in;
      trunc_ff <= trunc_in;
   end

   uasd_seq_store #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .append   (append),
      .clear    (seq_clear),
      .rd1_addr (sq_rd1_addr),
      .rd2_addr (sq_rd2_addr),
      .rd1_data (sq_rd1),
      .rd2_data (sq_rd2),
      .count1   (len1),
      .count2   (len2),
      .dropped  (dropped)
   );

   uasd_pos_map #(
      .MAX_LENGTH   (MAX_LENGTH),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_map (
      .clock    (clock),
      .wr1_en   (mp_wr1),
      .wr2_en   (mp_wr2),
      .wr_addr  (mp_wr_addr),
      .wr_data  (mp_wr_data),
      .rd_addr  (mp_rd_addr),
      .rd1_data (mp_rd1),
      .rd2_data (mp_rd2)
   );

   uasd_chunk_store #(
      .MAX_CHUNKS (MAX_CHUNKS),
      .REC_WIDTH  (RW)
   ) u_chunk (
      .clock   (clock),
      .wr_en   (ck_wr),
      .wr_addr (ck_wr_addr),
      .wr_data (ck_wr_data),
      .rd_addr (ck_rd_addr),
      .rd_data (ck_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_kind   = kind_ff;
   assign rsp_start_first  = sf_ff;
   assign rsp_start_second = ss_ff;
   assign rsp_chunk_length = len_ff;
   assign rsp_last_chunk   = last_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_truncated    = trunc_ff;

endmodule
